// ----- sv/kst_pkg.sv -----
// ----------------------------------------------------------------------------
// kst_pkg - keyed sum table shared types
// Request/result payloads, cell control bundle and status codes.
// ----------------------------------------------------------------------------
package kst_pkg;

	localparam int KST_DEPTH_DEF = 32;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_DUMP = 1'b1;

	localparam logic [2:0] ST_NEW   = 3'd0;
	localparam logic [2:0] ST_ACC   = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_DUMP  = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	typedef struct packed {
		logic        cmd;
		logic [31:0] key;
		logic [15:0] value;
	} kst_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] entry_key;
		logic [31:0] entry_total;
		logic        saturated;
		logic        last;
	} kst_res_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [31:0] total;
	} kst_entry_t;

	typedef struct packed {
		logic        lookup;
		logic        upd;
		logic        ins;
		logic        shift;
		logic [31:0] key;
		logic [31:0] total;
	} kst_cell_ctl_t;

endpackage

// ----- sv/keyed_sum_aggregation_table_unit.sv -----
// ----------------------------------------------------------------------------
// keyed_sum_aggregation_table_unit - group-by-key running sums
// Row of TABLE_DEPTH entry cells with a small sequencer in front.
// ----------------------------------------------------------------------------
// An add passes through the cycle of acceptance, a compare state in
// which every cell checks its key against the request, and an update state
// with the single saturating adder; its result strobes in the cycle after.
// A dump moves the whole row one cell toward the head each cycle and emits
// the head entry, with one result per cycle until the table is empty; an
// empty dump answers in the next cycle and keeps busy low.
// Results are shown for one cycle only and must be captured when res_valid
// is high.
module keyed_sum_aggregation_table_unit #(
	parameter int TABLE_DEPTH = kst_pkg::KST_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  kst_pkg::kst_req_t req,
	output logic             res_valid,
	output kst_pkg::kst_res_t res
);
	import kst_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_LOOKUP = 2'd1;
	localparam logic [1:0] S_UPDATE = 2'd2;
	localparam logic [1:0] S_DUMP   = 2'd3;

	logic [1:0]       state_q;
	kst_req_t         req_q;
	kst_res_t         res_q;
	logic             res_valid_q;
	logic             any_hit_s1;
	logic [31:0]      old_s1;
	kst_cell_ctl_t    ctl;
	kst_entry_t       ent [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] hit;
	logic [TABLE_DEPTH-1:0] vld;
	logic [31:0]      old_sel;
	logic [32:0]      sum;
	logic             sat;
	logic [31:0]      new_total;
	logic             full;
	logic             accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign full   = vld[TABLE_DEPTH-1];

	assign sum       = {1'b0, old_s1} + {17'b0, req_q.value};
	assign sat       = sum[32];
	assign new_total = sat ? '1 : sum[31:0];

	always_comb begin
		ctl.lookup = (state_q == S_LOOKUP);
		ctl.upd    = (state_q == S_UPDATE) && any_hit_s1;
		ctl.ins    = (state_q == S_UPDATE) && !any_hit_s1;
		ctl.shift  = (state_q == S_DUMP);
		ctl.key    = req_q.key;
		ctl.total  = any_hit_s1 ? new_total : {16'b0, req_q.value};
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		kst_entry_t nxt;
		logic       pv;
		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = ent[i+1];
		end
		if (i == 0) begin : g_head
			assign pv = 1'b1;
		end else begin : g_body
			assign pv = ent[i-1].valid;
		end
		kst_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_valid (pv),
			.next_in    (nxt),
			.entry      (ent[i]),
			.hit        (hit[i])
		);
		assign vld[i] = ent[i].valid;
	end

	always_comb begin
		old_sel = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			old_sel = old_sel | (hit[i] ? ent[i].total : 32'b0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.cmd == CMD_ADD) begin
							state_q <= S_LOOKUP;
						end else if (vld[0]) begin
							state_q <= S_DUMP;
						end else begin
							res_valid_q <= 1'b1;
						end
					end
				end
				S_LOOKUP: state_q <= S_UPDATE;
				S_UPDATE: begin
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_DUMP: begin
					res_valid_q <= 1'b1;
					if (!vld[1]) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == S_LOOKUP) begin
			any_hit_s1 <= |hit;
			old_s1     <= old_sel;
		end
		case (state_q)
			S_IDLE: begin
				res_q <= '{status: ST_EMPTY, entry_key: 32'b0, entry_total: 32'b0,
					saturated: 1'b0, last: 1'b1};
			end
			S_UPDATE: begin
				if (any_hit_s1) begin
					res_q <= '{status: ST_ACC, entry_key: req_q.key,
						entry_total: new_total, saturated: sat, last: 1'b1};
				end else if (!full) begin
					res_q <= '{status: ST_NEW, entry_key: req_q.key,
						entry_total: {16'b0, req_q.value}, saturated: 1'b0, last: 1'b1};
				end else begin
					res_q <= '{status: ST_FULL, entry_key: req_q.key,
						entry_total: 32'b0, saturated: 1'b0, last: 1'b1};
				end
			end
			S_DUMP: begin
				res_q <= '{status: ST_DUMP, entry_key: ent[0].key,
					entry_total: ent[0].total, saturated: 1'b0, last: !vld[1]};
			end
			default: res_q <= res_q;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit))
		else $error("more than one cell matched the key");

	a_fill_order: assert property (@(posedge clk) disable iff (!arst_n)
		((vld >> 1) & ~vld) == '0)
		else $error("occupied cells are not contiguous from the head");

	a_update_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE) |=> res_valid && res.last)
		else $error("add finished without a result");

	a_dump_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |=> res_valid && (res.status == ST_DUMP))
		else $error("dump cycle without a dump entry");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.last == !busy))
		else $error("last flag disagrees with sequencer state");

endmodule

// ----- sv/kst_cell.sv -----
// ----------------------------------------------------------------------------
// kst_cell - one table entry
// Holds key, total and valid; compares against the broadcast key, takes
// insert/update writes and shifts toward the head during a dump.
// ----------------------------------------------------------------------------
module kst_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kst_pkg::kst_cell_ctl_t ctl,
	input  logic                   prev_valid,
	input  kst_pkg::kst_entry_t    next_in,
	output kst_pkg::kst_entry_t    entry,
	output logic                   hit
);
	import kst_pkg::*;

	logic        valid_q;
	logic        hit_q;
	logic [31:0] key_q;
	logic [31:0] total_q;
	logic        ins_en;
	logic        upd_en;

	assign hit    = valid_q && (key_q == ctl.key);
	assign ins_en = ctl.ins && !valid_q && prev_valid;
	assign upd_en = ctl.upd && hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctl.shift) begin
				valid_q <= next_in.valid;
			end else if (ins_en) begin
				valid_q <= 1'b1;
			end
			if (ctl.lookup) begin
				hit_q <= hit;
			end else if (ctl.upd) begin
				hit_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q   <= next_in.key;
			total_q <= next_in.total;
		end else if (ins_en) begin
			key_q   <= ctl.key;
			total_q <= ctl.total;
		end else if (upd_en) begin
			total_q <= ctl.total;
		end
	end

	assign entry = '{valid: valid_q, key: key_q, total: total_q};

endmodule
